@@ design/btr_pkg.sv @@
// btr_pkg: shared constants, types and helpers of the bitmap text glyph renderer
// no dependencies; imported by the row sequencer, the top level, the checker and the bench
`timescale 1ns / 1ps

package btr_pkg;

  // default geometry of the font and the layout
  localparam int CHAR_W_DEF     = 8;
  localparam int LINE_H_DEF     = 12;
  localparam int GLYPHS_DEF     = 65536;
  localparam int GLYPH_ROWS_DEF = 12;

  localparam logic [9:0] COORD_MAX  = 10'd1023;
  localparam logic [9:0] WRAP_RESET = 10'd457;
  localparam int         LINE_GAP   = 3;

  // input item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_CHAR  = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  // character codes with a layout meaning
  localparam logic [15:0] CODE_TAB     = 16'h0009;
  localparam logic [15:0] CODE_NL      = 16'h000a;
  localparam logic [15:0] CODE_CR      = 16'h000d;
  localparam logic [15:0] CODE_SPACE   = 16'h0020;
  localparam logic [15:0] CODE_WIDE    = 16'd256;
  localparam logic [15:0] CODE_SURR_LO = 16'd55296;

  // glyph draw request from the layout logic to the row sequencer
  typedef struct packed {
    logic        start;
    logic [15:0] code;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] color;
  } glyph_req_t;

  // clamp an 11-bit coordinate sum to the screen
  function automatic logic [9:0] sat_coord(input logic [10:0] s);
    return (s > {1'b0, COORD_MAX}) ? COORD_MAX : s[9:0];
  endfunction

endpackage

@@ design/btr_if.sv @@
// btr_in_if and btr_out_if: valid/ready channels of the glyph renderer
// no dependencies beyond the plain payload widths
`timescale 1ns / 1ps

interface btr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [9:0]  start_x;
  logic [9:0]  start_y;
  logic [15:0] ink_color;
  logic [15:0] code;
  logic [3:0]  row;
  logic [15:0] row_bits;

  modport source (output valid, mode, start_x, start_y, ink_color, code, row, row_bits,
                  input ready);
  modport sink   (input valid, mode, start_x, start_y, ink_color, code, row, row_bits,
                  output ready);
endinterface

interface btr_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic [15:0] pixel_mask;
  logic [15:0] paint_color;
  logic        last_row;

  modport source (output valid, pixel_x, pixel_y, pixel_mask, paint_color, last_row,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_mask, paint_color, last_row,
                  output ready);
endinterface

@@ design/btr_font_mem.sv @@
// btr_font_mem: font row store, one write and one registered read port
// no package dependency; depth set by the top level
`timescale 1ns / 1ps

module btr_font_mem #(
  parameter int DEPTH = 786432,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/btr_row_seq.sv @@
// btr_row_seq: walks the rows of one glyph through the font store and
// delivers them on the result channel; uses btr_pkg and btr_out_if
`timescale 1ns / 1ps

module btr_row_seq #(
  parameter int GLYPH_ROWS = btr_pkg::GLYPH_ROWS_DEF,
  parameter int AW         = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  btr_pkg::glyph_req_t req,
  output logic                busy,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [15:0]         rd_data,
  btr_out_if.source           out_ch
);
  import btr_pkg::*;

  localparam int ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

  logic [ROW_W-1:0] row_cnt;
  logic [9:0]       row_y;
  logic [9:0]       g_x;
  logic [15:0]      g_color;

  // read stage: position fields that travel with the pending read
  logic        p1_valid;
  logic [9:0]  p1_x;
  logic [9:0]  p1_y;
  logic [15:0] p1_color;
  logic        p1_last;

  logic issue;
  logic out_load;

  assign out_load = p1_valid && (!out_ch.valid || out_ch.ready);
  assign issue    = busy && (!p1_valid || out_load);
  assign rd_en    = issue;

  // row counter and read address
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy    <= 1'b1;
      row_cnt <= '0;
      rd_addr <= AW'(req.code * GLYPH_ROWS);
      row_y   <= req.y;
      g_x     <= req.x;
      g_color <= req.color;
    end else if (issue) begin
      row_cnt <= row_cnt + 1'b1;
      rd_addr <= rd_addr + 1'b1;
      row_y   <= sat_coord({1'b0, row_y} + 11'd1);
      if (row_cnt == ROW_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // read stage tracks the font row on its way out of memory
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (issue) begin
      p1_valid <= 1'b1;
    end else if (out_load) begin
      p1_valid <= 1'b0;
    end
    if (issue) begin
      p1_x     <= g_x;
      p1_y     <= row_y;
      p1_color <= g_color;
      p1_last  <= (row_cnt == ROW_LAST);
    end
  end

  // output register holds a row until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (out_load) begin
      out_ch.pixel_x     <= p1_x;
      out_ch.pixel_y     <= p1_y;
      out_ch.pixel_mask  <= rd_data;
      out_ch.paint_color <= p1_color;
      out_ch.last_row    <= p1_last;
    end
  end

endmodule

@@ design/bitmap_text_glyph_renderer.sv @@
// bitmap_text_glyph_renderer: top level, cursor layout and font loading
// depends on btr_pkg, btr_if, btr_font_mem and btr_row_seq
`timescale 1ns / 1ps

// Usage
//   in_ch carries one item per transaction: mode 0 starts a string (origin
//   and ink color), mode 1 places a character, mode 2 loads one font row.
//   out_ch carries one transaction per glyph row: position, 16-pixel mask,
//   color and last_row on the final row of the glyph.
//   cfg_we/cfg_wdata write wrap_x; write it only while the block is idle.
// Timing
//   start, load and non-drawing character items do not hold in_ch.ready low.
//   a drawn glyph holds in_ch.ready low while its GLYPH_ROWS reads go out,
//   one row per cycle from the single font store read port while out_ch
//   does not stall; the first row is offered after the read address, the
//   registered font store read and the output register.
// Reset
//   rst clears the cursor, origin and color and sets wrap_x to 457; the
//   font store is not cleared and must be loaded before glyphs are drawn.
// Stall
//   when out_ch.ready is low the rows back up in a two-deep pipe and the
//   memory reads pause; no row is lost or repeated.

module bitmap_text_glyph_renderer #(
  parameter int CHAR_W     = btr_pkg::CHAR_W_DEF,
  parameter int LINE_H     = btr_pkg::LINE_H_DEF,
  parameter int GLYPHS     = btr_pkg::GLYPHS_DEF,
  parameter int GLYPH_ROWS = btr_pkg::GLYPH_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata,
  btr_in_if.sink     in_ch,
  btr_out_if.source  out_ch
);
  import btr_pkg::*;

  localparam int DEPTH = GLYPHS * GLYPH_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [10:0] ADV_1   = 11'(CHAR_W);
  localparam logic [10:0] ADV_2   = 11'(2 * CHAR_W);
  localparam logic [10:0] ADV_TAB = 11'(4 * CHAR_W);
  localparam logic [10:0] STEP_Y  = 11'(LINE_H + LINE_GAP);

  logic [9:0]  cursor_x;
  logic [9:0]  cursor_y;
  logic [9:0]  origin_x;
  logic [15:0] string_color;
  logic [9:0]  wrap_x;

  logic        seq_busy;
  glyph_req_t  req;
  logic        accept;
  logic        is_char;
  logic        narrow;
  logic        wide;
  logic        in_font;
  logic [10:0] adv;
  logic [9:0]  x_adv;
  logic [9:0]  cursor_x_next;
  logic [9:0]  cursor_y_next;
  logic        load_we;
  logic [AW-1:0] load_addr;
  logic        mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0] mem_rdata;

  assign in_ch.ready = !seq_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_char     = accept && (in_ch.mode == MODE_CHAR);

  // character classes
  assign narrow  = (in_ch.code > CODE_CR) && (in_ch.code < CODE_WIDE);
  assign wide    = (in_ch.code >= CODE_WIDE) && (in_ch.code < CODE_SURR_LO);
  assign in_font = ({1'b0, in_ch.code} < 17'(GLYPHS));

  // cursor advance, then newline or wrap
  always_comb begin
    if (in_ch.code == CODE_SPACE || narrow) begin
      adv = ADV_1;
    end else if (in_ch.code == CODE_TAB) begin
      adv = ADV_TAB;
    end else if (wide) begin
      adv = ADV_2;
    end else begin
      adv = '0;
    end
    x_adv = sat_coord({1'b0, cursor_x} + adv);
    if (in_ch.code == CODE_NL || x_adv > wrap_x) begin
      cursor_x_next = origin_x;
      cursor_y_next = sat_coord({1'b0, cursor_y} + STEP_Y);
    end else begin
      cursor_x_next = x_adv;
      cursor_y_next = cursor_y;
    end
  end

  // glyph request uses the cursor before the advance; space only moves
  assign req.start = is_char && (narrow || wide) && (in_ch.code != CODE_SPACE) && in_font;
  assign req.code  = in_ch.code;
  assign req.x     = cursor_x;
  assign req.y     = cursor_y;
  assign req.color = string_color;

  // font row load
  assign load_we   = accept && (in_ch.mode == MODE_LOAD) && in_font &&
                     ({1'b0, in_ch.row} < 5'(GLYPH_ROWS));
  assign load_addr = AW'(in_ch.code * GLYPH_ROWS + in_ch.row);

  // layout state and wrap register
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      origin_x     <= '0;
      string_color <= '0;
      wrap_x       <= WRAP_RESET;
    end else begin
      if (cfg_we) begin
        wrap_x <= cfg_wdata;
      end
      if (accept && in_ch.mode == MODE_START) begin
        origin_x     <= in_ch.start_x;
        cursor_x     <= in_ch.start_x;
        cursor_y     <= in_ch.start_y;
        string_color <= in_ch.ink_color;
      end else if (is_char) begin
        cursor_x <= cursor_x_next;
        cursor_y <= cursor_y_next;
      end
    end
  end

  btr_font_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_font (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (in_ch.row_bits),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  btr_row_seq #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .AW         (AW)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .busy    (seq_busy),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .out_ch  (out_ch)
  );

endmodule

@@ design/btr_checker.sv @@
// btr_checker: port-level assertions of the glyph renderer, bound to the top
// depends on btr_pkg for the mode codes
`timescale 1ns / 1ps

module btr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  pixel_x,
  input logic [15:0] pixel_mask,
  input logic        last_row
);
  import btr_pkg::*;

  // a stalled row keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_mask)
      && $stable(last_row))
    else $error("result row changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // only a character transaction makes the block busy
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && in_ready && in_mode == MODE_CHAR))
    else $error("input stalled without a drawn character");

endmodule

bind bitmap_text_glyph_renderer btr_checker u_btr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_mode    (in_ch.mode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pixel_x    (out_ch.pixel_x),
  .pixel_mask (out_ch.pixel_mask),
  .last_row   (out_ch.last_row)
);

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for bitmap_text_glyph_renderer
// depends on btr_pkg, btr_in_if/btr_out_if and the renderer top level
`timescale 1ns / 1ps

module tb_top;
  import btr_pkg::*;

  localparam logic [1:0] MODE_NONE    = 2'd3;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         LONG_HOLD    = 400;

  // one input transaction and one glyph row result
  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  start_x;
    logic [9:0]  start_y;
    logic [15:0] ink_color;
    logic [15:0] code;
    logic [3:0]  row;
    logic [15:0] row_bits;
  } text_item_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [15:0] pixel_mask;
    logic [15:0] paint_color;
    logic        last_row;
  } glyph_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [9:0] cfg_wdata;

  btr_in_if  in_ch ();
  btr_out_if out_ch ();

  bitmap_text_glyph_renderer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // pending items and expected glyph rows
  text_item_t pending_items[$];
  glyph_row_t expected_rows[$];

  // layout state mirrored from the block
  logic [9:0]  cur_x      = '0;
  logic [9:0]  cur_y      = '0;
  logic [9:0]  org_x      = '0;
  logic [15:0] ink        = '0;
  logic [9:0]  wrap_model = WRAP_RESET;
  logic [15:0] font_store [int];

  // stimulus bookkeeping: rows loaded per glyph and glyphs safe to draw
  bit [11:0] rows_loaded [int];
  int        drawable_codes[$];
  int        queued_count = 0;

  // driver and receiver control
  text_item_t drv_item = '0;
  bit         drv_holding = 1'b0;
  int         src_idle_left = 0;
  int         snk_idle_left = 0;
  int         long_hold_left = 0;
  bit         long_hold_req = 1'b0;
  bit         idle_enable = 1'b1;
  int         mismatch_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // known input values from time zero, then reset is released
  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = '0;
    in_ch.start_x     = '0;
    in_ch.start_y     = '0;
    in_ch.ink_color   = '0;
    in_ch.code        = '0;
    in_ch.row         = '0;
    in_ch.row_bits    = '0;
    out_ch.ready      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // saturating coordinate add
  function automatic logic [9:0] clamp_coord(logic [9:0] base, int unsigned step);
    int unsigned total;
    total = base + step;
    return (total > COORD_MAX) ? COORD_MAX : total[9:0];
  endfunction

  // layout predictor: updates the cursor and queues the rows a glyph draws
  function automatic void apply_text_item(text_item_t it);
    glyph_row_t gr;
    int         base_idx;
    bit         draws;
    draws = 1'b0;
    case (it.mode)
      MODE_START: begin
        org_x = it.start_x;
        cur_x = it.start_x;
        cur_y = it.start_y;
        ink   = it.ink_color;
      end
      MODE_LOAD: begin
        if (int'(it.code) < GLYPHS_DEF && int'(it.row) < GLYPH_ROWS_DEF)
          font_store[int'(it.code) * GLYPH_ROWS_DEF + int'(it.row)] = it.row_bits;
      end
      MODE_CHAR: begin
        draws = (it.code > CODE_CR && it.code < CODE_SURR_LO && it.code != CODE_SPACE &&
                 int'(it.code) < GLYPHS_DEF);
        // rows are taken at the cursor before it moves
        if (draws) begin
          base_idx = int'(it.code) * GLYPH_ROWS_DEF;
          for (int r = 0; r < GLYPH_ROWS_DEF; r++) begin
            gr.pixel_x     = cur_x;
            gr.pixel_y     = clamp_coord(cur_y, r);
            gr.pixel_mask  = font_store.exists(base_idx + r) ? font_store[base_idx + r] : '0;
            gr.paint_color = ink;
            gr.last_row    = (r == GLYPH_ROWS_DEF - 1);
            expected_rows.push_back(gr);
          end
        end
        if (it.code == CODE_SPACE) begin
          cur_x = clamp_coord(cur_x, CHAR_W_DEF);
        end else if (it.code == CODE_TAB) begin
          cur_x = clamp_coord(cur_x, 4 * CHAR_W_DEF);
        end else if (it.code > CODE_CR && it.code < CODE_WIDE) begin
          cur_x = clamp_coord(cur_x, CHAR_W_DEF);
        end else if (it.code >= CODE_WIDE && it.code < CODE_SURR_LO) begin
          cur_x = clamp_coord(cur_x, 2 * CHAR_W_DEF);
        end
        if (it.code == CODE_NL || cur_x > wrap_model) begin
          cur_x = org_x;
          cur_y = clamp_coord(cur_y, LINE_H_DEF + LINE_GAP);
        end
      end
      default: ;
    endcase
  endfunction

  // driver: offers pending items, predicts each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      drv_holding   = 1'b0;
      src_idle_left = 0;
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_text_item(drv_item);
        drv_holding = 1'b0;
        if (idle_enable && $urandom_range(0, 6) == 0)
          src_idle_left = $urandom_range(1, 18);
      end
      if (!drv_holding) begin
        if (src_idle_left > 0) begin
          src_idle_left--;
        end else if (pending_items.size() != 0) begin
          drv_item    = pending_items.pop_front();
          drv_holding = 1'b1;
        end
      end
      in_ch.valid     <= drv_holding;
      in_ch.mode      <= drv_item.mode;
      in_ch.start_x   <= drv_item.start_x;
      in_ch.start_y   <= drv_item.start_y;
      in_ch.ink_color <= drv_item.ink_color;
      in_ch.code      <= drv_item.code;
      in_ch.row       <= drv_item.row;
      in_ch.row_bits  <= drv_item.row_bits;
    end
  end

  // receiver ready: random stall bursts plus one long hold-off on request
  always @(posedge clk) begin
    bit rdy;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (long_hold_req) begin
        long_hold_left = LONG_HOLD;
        long_hold_req  = 1'b0;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        rdy = 1'b0;
      end else if (snk_idle_left > 0) begin
        snk_idle_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (idle_enable && $urandom_range(0, 7) == 0)
          snk_idle_left = $urandom_range(1, 18);
      end
      out_ch.ready <= rdy;
    end
  end

  // monitor: compare each row transaction with the oldest expected row
  always @(posedge clk) begin
    glyph_row_t got;
    glyph_row_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.pixel_x     = out_ch.pixel_x;
      got.pixel_y     = out_ch.pixel_y;
      got.pixel_mask  = out_ch.pixel_mask;
      got.paint_color = out_ch.paint_color;
      got.last_row    = out_ch.last_row;
      if (expected_rows.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected row: x=%0d y=%0d mask=%h color=%h last=%b",
                   got.pixel_x, got.pixel_y, got.pixel_mask, got.paint_color, got.last_row);
        mismatch_count++;
      end else begin
        want = expected_rows.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10)
            $display("row mismatch: expected x=%0d y=%0d mask=%h color=%h last=%b,",
                     want.pixel_x, want.pixel_y, want.pixel_mask, want.paint_color,
                     want.last_row,
                     " got x=%0d y=%0d mask=%h color=%h last=%b",
                     got.pixel_x, got.pixel_y, got.pixel_mask,
                     got.paint_color, got.last_row);
          mismatch_count++;
        end
      end
    end
  end

  // item builders; unused fields carry random noise
  function automatic text_item_t new_item(logic [1:0] m);
    text_item_t it;
    it.mode      = m;
    it.start_x   = 10'($urandom);
    it.start_y   = 10'($urandom);
    it.ink_color = 16'($urandom);
    it.code      = 16'($urandom);
    it.row       = 4'($urandom);
    it.row_bits  = 16'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] pick_bits();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_item(text_item_t it);
    pending_items.push_back(it);
    queued_count++;
  endtask

  task automatic queue_start(logic [9:0] x, logic [9:0] y, logic [15:0] color);
    text_item_t it;
    it           = new_item(MODE_START);
    it.start_x   = x;
    it.start_y   = y;
    it.ink_color = color;
    queue_item(it);
  endtask

  task automatic queue_char(int c);
    text_item_t it;
    it      = new_item(MODE_CHAR);
    it.code = 16'(c);
    queue_item(it);
  endtask

  // a glyph becomes drawable once all of its rows are loaded
  task automatic queue_load(int c, int r, logic [15:0] bits);
    text_item_t it;
    bit         was_full;
    it          = new_item(MODE_LOAD);
    it.code     = 16'(c);
    it.row      = 4'(r);
    it.row_bits = bits;
    queue_item(it);
    if (r < GLYPH_ROWS_DEF) begin
      if (!rows_loaded.exists(c)) rows_loaded[c] = '0;
      was_full = &rows_loaded[c];
      rows_loaded[c][r] = 1'b1;
      if (!was_full && &rows_loaded[c] && c > int'(CODE_CR) && c < int'(CODE_SURR_LO) &&
          c != int'(CODE_SPACE))
        drawable_codes.push_back(c);
    end
  endtask

  task automatic load_glyph(int c);
    for (int r = 0; r < GLYPH_ROWS_DEF; r++) queue_load(c, r, pick_bits());
  endtask

  // noise between characters: unused mode, row rewrites, stray and ignored loads
  task automatic queue_noise();
    case ($urandom_range(0, 3))
      0: queue_item(new_item(MODE_NONE));
      1: queue_load(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)],
                    $urandom_range(0, GLYPH_ROWS_DEF - 1), pick_bits());
      2: queue_load($urandom_range(0, 65535), $urandom_range(0, 15), pick_bits());
      default: queue_load($urandom_range(0, 65535), $urandom_range(GLYPH_ROWS_DEF, 15),
                          pick_bits());
    endcase
  endtask

  function automatic int pick_char_code();
    int sel;
    int c;
    sel = $urandom_range(0, 99);
    if (sel < 62) return drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
    if (sel < 72) return int'(CODE_SPACE);
    if (sel < 77) return int'(CODE_TAB);
    if (sel < 82) return int'(CODE_NL);
    // control codes that do not advance the cursor
    if (sel < 90) begin
      c = $urandom_range(0, 11);
      return (c < 9) ? c : c + 2;
    end
    return $urandom_range(int'(CODE_SURR_LO), 65535);
  endfunction

  // strings: a start item then a run of characters with some noise
  task automatic run_text_phase(int n_items);
    int stop_at;
    int len;
    stop_at = queued_count + n_items;
    while (queued_count < stop_at) begin
      queue_start(10'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, 300)),
                  10'($urandom_range(0, 1023)), 16'($urandom));
      len = $urandom_range(4, 20);
      repeat (len) begin
        if ($urandom_range(0, 11) == 0) queue_noise();
        else queue_char(pick_char_code());
      end
    end
  endtask

  // wait until every item is taken and every row is back, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || drv_holding || expected_rows.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_wrap(logic [9:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    wrap_model = value;
    @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    wait (rst == 1'b0);
    @(negedge clk);

    // font setup: extremes of both glyph widths plus a few random glyphs
    load_glyph(int'(CODE_CR) + 1);
    load_glyph(255);
    load_glyph(int'(CODE_WIDE));
    load_glyph(int'(CODE_SURR_LO) - 1);
    load_glyph(65);
    load_glyph('h4e00);
    load_glyph('hac00);
    repeat (3) load_glyph($urandom_range(15, 254));
    repeat (3) load_glyph($urandom_range(257, 55294));
    queue_load(65535, 3, 16'h1234);
    queue_load(0, GLYPH_ROWS_DEF - 1, 16'hffff);

    // directed string at the reset wrap value
    queue_start(10'd0, 10'd0, 16'hffff);
    queue_char(int'(CODE_CR) + 1);
    queue_char(255);
    queue_char(int'(CODE_WIDE));
    queue_char(int'(CODE_SURR_LO) - 1);
    queue_char(int'(CODE_SPACE));
    queue_char(int'(CODE_TAB));
    queue_char(65);
    queue_char(0);
    queue_char(8);
    queue_char(11);
    queue_char(12);
    queue_char(int'(CODE_CR));
    queue_char(int'(CODE_SURR_LO));
    queue_char(65535);
    queue_char(int'(CODE_NL));
    queue_char(65);
    queue_item(new_item(MODE_NONE));
    queue_load(int'(CODE_CR) + 1, GLYPH_ROWS_DEF, 16'h0000);
    queue_load(255, 15, 16'h0000);
    // wrap past the limit and pixel_y saturation near the bottom
    queue_start(10'd450, 10'd1020, 16'h8001);
    queue_char(int'(CODE_WIDE));
    queue_char(int'(CODE_SURR_LO) - 1);
    queue_char(int'(CODE_NL));
    wait_idle();

    // widest wrap: cursor x saturates at the right edge without wrapping
    write_wrap(10'd1023);
    queue_start(10'd1000, 10'd3, 16'h0000);
    repeat (3) queue_char(int'(CODE_WIDE));
    queue_char(int'(CODE_TAB));
    queue_char(int'(CODE_SPACE));
    queue_char(int'(CODE_CR) + 1);
    queue_start(10'd1023, 10'd1023, 16'h5a5a);
    queue_char(int'(CODE_NL));
    queue_char(int'(CODE_CR) + 1);
    wait_idle();

    // zero wrap: every advance wraps
    write_wrap(10'd0);
    run_text_phase(30);
    wait_idle();

    // receiver holds off for a long stretch while strings keep coming
    write_wrap(10'($urandom_range(100, 900)));
    long_hold_req = 1'b1;
    run_text_phase(40);
    wait_idle();

    write_wrap(10'd1023);
    run_text_phase(30);
    wait_idle();

    write_wrap(10'($urandom_range(0, 1023)));
    run_text_phase(30);
    wait_idle();

    // last part without idling
    idle_enable = 1'b0;
    write_wrap(WRAP_RESET);
    run_text_phase(30);
    wait_idle();

    if (mismatch_count == 0 && expected_rows.size() == 0)
      $display("bitmap_text_glyph_renderer verification clean");
    else
      $display("bitmap_text_glyph_renderer verification failed");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("bitmap_text_glyph_renderer verification failed");
    $finish;
  end

endmodule

@@ files.f @@
design/btr_pkg.sv
design/btr_if.sv
design/btr_font_mem.sv
design/btr_row_seq.sv
design/bitmap_text_glyph_renderer.sv
design/btr_checker.sv
tb/tb_top.sv
